// ===== hw/rtl/angle_bias_kalman_filter_core_macros.svh =====
// Assertion macros shared by the angle/bias Kalman filter RTL.
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abkf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ABKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abkf: next-cycle check failed");

`endif

// ===== hw/rtl/abkf_pkg.sv =====
// Types, constants and arithmetic helpers of the angle/bias Kalman filter.
package abkf_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int WORD_W    = 32;
  localparam int DT_W      = 24;
  localparam int FRAC_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W  = 36;
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int RND_W    = PROD_W - FRAC_W;
  localparam int SAT_IN_W = 48;
  localparam int INNER_W  = 36;

  localparam int NUM_W  = WORD_W + FRAC_W;
  localparam int DEN_W  = WORD_W + 2;
  localparam int NMAG_W = NUM_W;
  localparam int DMAG_W = DEN_W;
  localparam int QUO_W  = WORD_W + 1;
  localparam int REM_W  = DMAG_W + 1;
  localparam int CNT_W  = $clog2(NMAG_W);

  localparam logic [WORD_W-1:0] PNA_RST = WORD_W'(16777);
  localparam logic [WORD_W-1:0] PNB_RST = WORD_W'(50332);
  localparam logic [WORD_W-1:0] MN_RST  = WORD_W'(503316);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PNA,
    CFG_PNB,
    CFG_MN,
    CFG_IA,
    CFG_IB
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M_ANG,
    ST_W_ANG,
    ST_M_P11,
    ST_W_P11,
    ST_M_INNER,
    ST_W_INNER,
    ST_M_PNB,
    ST_W_PNB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_M_K0Y,
    ST_W_K0Y,
    ST_M_K1Y,
    ST_W_K1Y,
    ST_M_C10,
    ST_W_C10,
    ST_M_C11,
    ST_W_C11,
    ST_M_C00,
    ST_W_C00,
    ST_M_C01,
    ST_W_C01,
    ST_OUT
  } state_e;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Round half up to the result format: floor((p + half) / 2^24).
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] tmp;
    tmp = p + RND_HALF;
    return $signed(tmp[PROD_W-1:FRAC_W]);
  endfunction

  // Clamp to a signed word of sat_w bits, returned sign-extended to WORD_W.
  function automatic logic signed [WORD_W-1:0] sat_word(
    input logic signed [SAT_IN_W-1:0] v,
    input int                         sat_w
  );
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = $signed((SAT_IN_W'(1) << (sat_w - 1)) - SAT_IN_W'(1));
    lo = ~hi;
    if (v > hi) begin
      return hi[WORD_W-1:0];
    end else if (v < lo) begin
      return lo[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/abkf_if.sv =====
// Valid/ready channel interfaces of the angle/bias Kalman filter.
interface abkf_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       measured_angle;
  logic signed [31:0]       measured_rate;
  logic        [23:0]       time_step;

  modport source (output valid, measured_angle, measured_rate, time_step, input ready);
  modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface abkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] unbiased_rate;
  logic signed [31:0] bias_estimate;

  modport source (output valid, filtered_angle, unbiased_rate, bias_estimate, input ready);
  modport sink   (input valid, filtered_angle, unbiased_rate, bias_estimate, output ready);
endinterface

interface abkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/abkf_mul.sv =====
// Shared signed multiplier with a registered product.
module abkf_mul import abkf_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/abkf_div.sv =====
// Restoring divider, one quotient bit per cycle, two dividends over one divisor.
module abkf_div import abkf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NUM_W-1:0]  num_i [2],
  input  logic signed [DEN_W-1:0]  den_i,
  output logic                     busy_o,
  output logic signed [WORD_W-1:0] quo_o [2]
);

  localparam int SAT_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam logic [SAT_IN_W-1:0] BIG = SAT_IN_W'(1) << (WORD_W + 8);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DMAG_W-1:0] dmag_q;
  logic              zero_q;
  logic [NMAG_W-1:0] nsh_q  [2];
  logic [REM_W-1:0]  rem_q  [2];
  logic [QUO_W-1:0]  quo_q  [2];
  logic              neg_q  [2];
  logic              ovf_q  [2];

  logic [DMAG_W-1:0] dmag;
  logic [NMAG_W-1:0] nmag  [2];
  logic [REM_W-1:0]  trial [2];

  assign dmag = den_i[DEN_W-1] ? DMAG_W'(-den_i) : DMAG_W'(den_i);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nmag[l]  = num_i[l][NUM_W-1] ? NMAG_W'(-num_i[l]) : NMAG_W'(num_i[l]);
      trial[l] = {rem_q[l][REM_W-2:0], nsh_q[l][cnt_q]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dmag_q <= dmag;
      zero_q <= (den_i == '0);
      for (int l = 0; l < 2; l++) begin
        nsh_q[l] <= nmag[l];
        rem_q[l] <= REM_W'(nmag[l][NMAG_W-1:QUO_W]);
        quo_q[l] <= '0;
        neg_q[l] <= num_i[l][NUM_W-1] ^ den_i[DEN_W-1];
        // quotient would need more than QUO_W bits
        ovf_q[l] <= (REM_W'(nmag[l][NMAG_W-1:QUO_W]) >= REM_W'(dmag));
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        if (trial[l] >= REM_W'(dmag_q)) begin
          rem_q[l] <= trial[l] - REM_W'(dmag_q);
          quo_q[l] <= {quo_q[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[l] <= trial[l];
          quo_q[l] <= {quo_q[l][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic signed [SAT_IN_W-1:0] mag;
    for (int l = 0; l < 2; l++) begin
      mag = ovf_q[l] ? $signed(BIG) : $signed(SAT_IN_W'(quo_q[l]));
      if (zero_q) begin
        quo_o[l] = '0;
      end else begin
        quo_o[l] = sat_word(neg_q[l] ? -mag : mag, SAT_W);
      end
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== hw/rtl/angle_bias_kalman_filter_core.sv =====
// Top level of the two-state angle/gyro-bias Kalman filter core.
//
// Fuses an angle sample with a gyro rate each request: predict with rate*dt,
// then correct with gains from the innovation variance. Each request makes
// ten passes through the shared multiplier and runs a 33-step divider that
// forms both gains at once. The input is not ready while a request is in work;
// a finished result waits in an output register, so the next request can be
// taken before it is consumed. Any write to registers 0..4 reloads angle and
// bias from the initial registers and clears the covariance; writes to other
// indexes are dropped.
`include "angle_bias_kalman_filter_core_macros.svh"

module angle_bias_kalman_filter_core import abkf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  abkf_in_if.sink   in_i,
  abkf_cfg_if.sink  cfg_i,
  abkf_out_if.source out_o
);

  localparam int SAT_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

  state_e state_q, state_d;

  logic [WORD_W-1:0]        pna_q, pnb_q, mn_q;
  logic signed [WORD_W-1:0] ia_q, ib_q;
  logic signed [WORD_W-1:0] ang_q, bias_q, c00_q, c01_q, c10_q, c11_q;

  logic signed [WORD_W-1:0]  ma_q, mr_q, rate_q, y_q, k0_q, k1_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [INNER_W-1:0] inner_q;
  logic signed [WORD_W-1:0]  fa_q;
  logic                      out_valid_q;

  logic in_fire, cfg_fire, cfg_hit, out_load;
  logic signed [WORD_W-1:0] ia_new, ib_new;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RND_W-1:0]   rv;
  logic signed [SAT_IN_W-1:0] rv_x;
  logic signed [MUL_B_W-1:0] dt_b;

  logic                     div_start, div_busy;
  logic signed [NUM_W-1:0]  div_num [2];
  logic signed [DEN_W-1:0]  div_den;
  logic signed [WORD_W-1:0] div_quo [2];

  assign in_fire  = in_i.valid & in_i.ready;
  assign cfg_fire = cfg_i.valid & cfg_i.ready;

  // Register decode; also the values the reload sees.
  always_comb begin
    cfg_hit = 1'b1;
    ia_new  = ia_q;
    ib_new  = ib_q;
    unique case (cfg_i.index)
      CFG_PNA, CFG_PNB, CFG_MN: ;
      CFG_IA:  ia_new = $signed(cfg_i.data);
      CFG_IB:  ib_new = $signed(cfg_i.data);
      default: cfg_hit = 1'b0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    cfg_i.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cfg_i.ready = 1'b1;
        in_i.ready  = ~cfg_i.valid;
        if (in_i.valid && !cfg_i.valid) begin
          state_d = ST_RATE;
        end
      end
      ST_RATE:      state_d = ST_M_ANG;
      ST_M_ANG:     state_d = ST_W_ANG;
      ST_W_ANG:     state_d = ST_M_P11;
      ST_M_P11:     state_d = ST_W_P11;
      ST_W_P11:     state_d = ST_M_INNER;
      ST_M_INNER:   state_d = ST_W_INNER;
      ST_W_INNER:   state_d = ST_M_PNB;
      ST_M_PNB:     state_d = ST_W_PNB;
      ST_W_PNB:     state_d = ST_DIV_START;
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = ST_M_K0Y;
        end
      end
      ST_M_K0Y:     state_d = ST_W_K0Y;
      ST_W_K0Y:     state_d = ST_M_K1Y;
      ST_M_K1Y:     state_d = ST_W_K1Y;
      ST_W_K1Y:     state_d = ST_M_C10;
      ST_M_C10:     state_d = ST_W_C10;
      ST_W_C10:     state_d = ST_M_C11;
      ST_M_C11:     state_d = ST_W_C11;
      ST_W_C11:     state_d = ST_M_C00;
      ST_M_C00:     state_d = ST_W_C00;
      ST_W_C00:     state_d = ST_M_C01;
      ST_M_C01:     state_d = ST_W_C01;
      ST_W_C01:     state_d = ST_OUT;
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Multiplier operand select.
  assign dt_b = $signed(MUL_B_W'(dt_q));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_ANG:   begin mul_a = MUL_A_W'(rate_q);            mul_b = dt_b; end
      ST_M_P11:   begin mul_a = MUL_A_W'(c11_q);             mul_b = dt_b; end
      ST_M_INNER: begin mul_a = inner_q;                     mul_b = dt_b; end
      ST_M_PNB:   begin mul_a = $signed(MUL_A_W'(pnb_q));    mul_b = dt_b; end
      ST_M_K0Y:   begin mul_a = MUL_A_W'(k0_q); mul_b = MUL_B_W'(y_q);   end
      ST_M_K1Y:   begin mul_a = MUL_A_W'(k1_q); mul_b = MUL_B_W'(y_q);   end
      ST_M_C10:   begin mul_a = MUL_A_W'(k1_q); mul_b = MUL_B_W'(c00_q); end
      ST_M_C11:   begin mul_a = MUL_A_W'(k1_q); mul_b = MUL_B_W'(c01_q); end
      ST_M_C00:   begin mul_a = MUL_A_W'(k0_q); mul_b = MUL_B_W'(c00_q); end
      ST_M_C01:   begin mul_a = MUL_A_W'(k0_q); mul_b = MUL_B_W'(c01_q); end
      default: ;
    endcase
  end

  abkf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign rv   = rnd(prod);
  assign rv_x = SAT_IN_W'(rv);

  // Gains: P00*2^24 / S and P10*2^24 / S with S = P00 + R.
  assign div_den    = DEN_W'(c00_q) + $signed(DEN_W'(mn_q));
  assign div_num[0] = $signed({c00_q, {FRAC_W{1'b0}}});
  assign div_num[1] = $signed({c10_q, {FRAC_W{1'b0}}});

  abkf_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pna_q       <= PNA_RST;
      pnb_q       <= PNB_RST;
      mn_q        <= MN_RST;
      ia_q        <= '0;
      ib_q        <= '0;
      ang_q       <= '0;
      bias_q      <= '0;
      c00_q       <= '0;
      c01_q       <= '0;
      c10_q       <= '0;
      c11_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire && cfg_hit) begin
        case (cfg_i.index)
          CFG_PNA: pna_q <= cfg_i.data;
          CFG_PNB: pnb_q <= cfg_i.data;
          CFG_MN:  mn_q  <= cfg_i.data;
          CFG_IA:  ia_q  <= $signed(cfg_i.data);
          CFG_IB:  ib_q  <= $signed(cfg_i.data);
          default: ;
        endcase
        ang_q  <= sat_word(SAT_IN_W'(ia_new), SAT_W);
        bias_q <= sat_word(SAT_IN_W'(ib_new), SAT_W);
        c00_q  <= '0;
        c01_q  <= '0;
        c10_q  <= '0;
        c11_q  <= '0;
      end
      case (state_q)
        ST_W_ANG: ang_q <= sat_word(SAT_IN_W'(ang_q) + rv_x, SAT_W);
        ST_W_P11: begin
          // old P01 and P10 feed both the inner term and their own update
          c01_q <= sat_word(SAT_IN_W'(c01_q) - rv_x, SAT_W);
          c10_q <= sat_word(SAT_IN_W'(c10_q) - rv_x, SAT_W);
        end
        ST_W_INNER: c00_q  <= sat_word(SAT_IN_W'(c00_q) + rv_x, SAT_W);
        ST_W_PNB:   c11_q  <= sat_word(SAT_IN_W'(c11_q) + rv_x, SAT_W);
        ST_W_K0Y:   ang_q  <= sat_word(SAT_IN_W'(ang_q) + rv_x, SAT_W);
        ST_W_K1Y:   bias_q <= sat_word(SAT_IN_W'(bias_q) + rv_x, SAT_W);
        ST_W_C10:   c10_q  <= sat_word(SAT_IN_W'(c10_q) - rv_x, SAT_W);
        ST_W_C11:   c11_q  <= sat_word(SAT_IN_W'(c11_q) - rv_x, SAT_W);
        ST_W_C00:   c00_q  <= sat_word(SAT_IN_W'(c00_q) - rv_x, SAT_W);
        ST_W_C01:   c01_q  <= sat_word(SAT_IN_W'(c01_q) - rv_x, SAT_W);
        default: ;
      endcase
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ma_q <= in_i.measured_angle;
      mr_q <= in_i.measured_rate;
      dt_q <= in_i.time_step;
    end
    case (state_q)
      ST_RATE:  rate_q  <= sat_word(SAT_IN_W'(mr_q) - SAT_IN_W'(bias_q), SAT_W);
      ST_W_P11: inner_q <= INNER_W'(rv_x - SAT_IN_W'(c01_q) - SAT_IN_W'(c10_q)
                                    + $signed(SAT_IN_W'(pna_q)));
      ST_DIV_START: y_q <= sat_word(SAT_IN_W'(ma_q) - SAT_IN_W'(ang_q), SAT_W);
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          k0_q <= div_quo[0];
          k1_q <= div_quo[1];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      fa_q <= ang_q;
      out_o.unbiased_rate <= rate_q;
      out_o.bias_estimate <= bias_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_angle = fa_q;

  `ABKF_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_fire, state_q == ST_RATE)
  `ABKF_ASSERT_NEXT(a_cfg_clears_cov, clk_i, rst_ni, cfg_fire && cfg_hit, (c00_q | c01_q | c10_q | c11_q) == '0)
  `ABKF_ASSERT_IMP(a_div_only_in_wait, clk_i, rst_ni, div_busy, state_q == ST_DIV_WAIT)
  `ABKF_ASSERT_NEXT(a_div_done_moves, clk_i, rst_ni, (state_q == ST_DIV_WAIT) && !div_busy, state_q == ST_M_K0Y)

endmodule

// ===== tb/abkf_tb_if.sv =====
// Free-running clock generator of the testbench.
module abkf_tb_clkgen (
  output logic clk_o
);
  initial begin
    clk_o = 1'b0;
    forever #2 clk_o = ~clk_o;
  end
endmodule

// ===== tb/angle_bias_kalman_filter_core_test.sv =====
// Testbench of the angle/gyro-bias Kalman filter core: directed, back-pressure and random requests.
module angle_bias_kalman_filter_core_test;
  import abkf_pkg::*;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic signed [31:0] bias;
  } filt_out_t;

  logic clk_i;
  logic rst_ni;
  abkf_in_if  in_if ();
  abkf_out_if out_if ();
  abkf_cfg_if cfg_if ();

  abkf_tb_clkgen u_clk (.clk_o(clk_i));

  angle_bias_kalman_filter_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .cfg_i (cfg_if.sink),
    .out_o (out_if.source)
  );

  // Predictor state.
  logic [31:0] noise_ang, noise_bias, noise_meas, init_ang, init_bias;
  longint est_ang, est_bias, p_aa, p_ab, p_ba, p_bb;

  filt_out_t expected_q[$];
  int unsigned err_cnt;
  int unsigned result_cnt;
  int unsigned hold_cycles;
  bit quiet_phase;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round24(input longint v);
    return (v + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic void reload_state();
    est_ang  = longint'($signed(init_ang));
    est_bias = longint'($signed(init_bias));
    p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
  endfunction

  function automatic void apply_cfg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      CFG_PNA: noise_ang = val;
      CFG_PNB: noise_bias = val;
      CFG_MN:  noise_meas = val;
      CFG_IA:  init_ang = val;
      CFG_IB:  init_bias = val;
      default: return;
    endcase
    reload_state();
  endfunction

  function automatic filt_out_t kalman_step(input logic signed [31:0] ma,
                                            input logic signed [31:0] mr,
                                            input logic [23:0] dts);
    longint dt, rate, inner, s, k0, k1, y, q00, q01, q10, q11;
    filt_out_t r;
    dt = longint'(dts);
    q00 = p_aa; q01 = p_ab; q10 = p_ba; q11 = p_bb;
    k0 = 0; k1 = 0;
    rate = clamp32(longint'(mr) - est_bias);
    est_ang = clamp32(est_ang + round24(dt * rate));
    inner = round24(dt * q11) - q01 - q10 + longint'(noise_ang);
    q00 = clamp32(q00 + round24(dt * inner));
    q01 = clamp32(q01 - round24(dt * q11));
    q10 = clamp32(q10 - round24(dt * q11));
    q11 = clamp32(q11 + round24(longint'(noise_bias) * dt));
    s = q00 + longint'(noise_meas);
    if (s != 0) begin
      k0 = clamp32((q00 * (64'sd1 <<< 24)) / s);
      k1 = clamp32((q10 * (64'sd1 <<< 24)) / s);
    end
    y = clamp32(longint'(ma) - est_ang);
    est_ang = clamp32(est_ang + round24(k0 * y));
    est_bias = clamp32(est_bias + round24(k1 * y));
    p_aa = clamp32(q00 - round24(k0 * q00));
    p_ab = clamp32(q01 - round24(k0 * q01));
    p_ba = clamp32(q10 - round24(k1 * q00));
    p_bb = clamp32(q11 - round24(k1 * q01));
    r.angle = est_ang[31:0];
    r.rate  = rate[31:0];
    r.bias  = est_bias[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // Source side. Valid stays up after an accept; the next task call replaces
  // or drops it, or the drain drops it, so no signal is assigned twice at one edge.
  task automatic send_request(input logic [31:0] ma, input logic [31:0] mr,
                              input logic [23:0] dts);
    cfg_if.valid <= 1'b0;
    while (!quiet_phase && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.measured_angle <= ma;
    in_if.measured_rate <= mr;
    in_if.time_step <= dts;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(kalman_step(ma, mr, dts));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_cfg(idx, val);
  endtask

  task automatic drain_results();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_dt();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(1000));
      default: return 24'($urandom_range(20000, 2000));
    endcase
  endfunction

  // Sink side and checker.
  always @(posedge clk_i) begin
    filt_out_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        result_cnt++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_if.filtered_angle, 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (out_if.filtered_angle !== want.angle)
            report_mismatch("filtered_angle", out_if.filtered_angle, want.angle);
          if (out_if.unbiased_rate !== want.rate)
            report_mismatch("unbiased_rate", out_if.unbiased_rate, want.rate);
          if (out_if.bias_estimate !== want.bias)
            report_mismatch("bias_estimate", out_if.bias_estimate, want.bias);
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet_phase || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic test_directed();
    write_reg(CFG_PNA, 32'd16777);
    send_request(32'sh7fffffff, 32'sh80000000, 24'hffffff);
    send_request(32'sh80000000, 32'sh7fffffff, 24'hffffff);
    send_request(32'sd0, 32'sd0, 24'd0);
    send_request(32'sh00010000, 32'sh00008000, 24'd16777);
    drain_results();
    // Zero innovation variance: all noise zero on a fresh covariance.
    write_reg(CFG_PNA, 32'd0);
    write_reg(CFG_PNB, 32'd0);
    write_reg(CFG_MN, 32'd0);
    send_request(32'sh00050000, 32'sh00001000, 24'd0);
    send_request(32'sh00050000, 32'sh00001000, 24'd100);
    drain_results();
    // Huge noise to push gains and covariance to saturation.
    write_reg(CFG_PNA, 32'hffffffff);
    write_reg(CFG_PNB, 32'hffffffff);
    write_reg(CFG_MN, 32'd1);
    write_reg(CFG_IA, 32'h7fffffff);
    write_reg(CFG_IB, 32'h80000000);
    for (int i = 0; i < 8; i++)
      send_request(i[0] ? 32'sh80000000 : 32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
    drain_results();
    // Out-of-range index is dropped without reload.
    write_reg(3'd5, 32'h12345678);
    write_reg(3'd7, 32'hffffffff);
    send_request(32'sd0, 32'sd0, 24'd1000);
    drain_results();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        drain_results();
        write_reg(3'($urandom_range(7)), $urandom_range(1) ? $urandom : $urandom_range(600000));
      end
      quiet_phase = (i >= 300 && i < 450);
      if ($urandom_range(3) == 0)
        send_request($urandom, $urandom, rand_dt());
      else
        send_request(32'($signed(18'($urandom))), 32'($signed(20'($urandom))), rand_dt());
    end
    quiet_phase = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++)
      send_request($urandom, $urandom, rand_dt());
    drain_results();
    for (int i = 0; i < 6; i++)
      send_request($urandom, $urandom, 24'($urandom));
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.measured_angle = '0;
    in_if.measured_rate = '0;
    in_if.time_step = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    result_cnt = 0;
    hold_cycles = 0;
    quiet_phase = 1'b0;
    noise_ang = 32'd16777;
    noise_bias = 32'd50332;
    noise_meas = 32'd503316;
    init_ang = '0;
    init_bias = '0;
    reload_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1180);
    drain_results();
    $display("covered %0d results over directed extremes, config reloads,", result_cnt);
    $display("zero-variance and saturating gains, back-pressure and random requests");
    if (err_cnt == 0) begin
      $display("angle_bias_kalman_filter_core test passed");
    end else begin
      $display("angle_bias_kalman_filter_core test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("angle_bias_kalman_filter_core test failed");
    $finish;
  end
endmodule
